>>> sv/mdota_pkg.sv
`timescale 1ns / 1ps
// Package for the multi-door open-timeout alarm: event codes, widths, reset limits
// and the command and status structs passed between the top level and the door cells.
// It has no dependencies of its own.
package mdota_pkg;

    localparam int DOOR_COUNT_DEF       = 8;
    localparam int TICKS_PER_SECOND_DEF = 100;

    localparam int MODE_W    = 3;
    localparam int DOOR_W    = 3;
    localparam int PAYLOAD_W = 8;
    localparam int MASK_W    = 8;
    localparam int ELAPSED_W = 16;
    localparam int LIMIT_W   = 15;

    localparam logic [LIMIT_W-1:0]   LOCAL_RESET   = 15'd300;
    localparam logic [LIMIT_W-1:0]   CENTRAL_RESET = 15'd700;
    localparam logic [LIMIT_W-1:0]   LIMIT_MAX     = 15'd32767;
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX   = 16'hFFFF;

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK      = 3'd0,
        MODE_SENSOR    = 3'd1,
        MODE_CLEAR     = 3'd2,
        MODE_ARM       = 3'd3,
        MODE_LOCAL_LIM = 3'd4,
        MODE_CENT_LIM  = 3'd5,
        MODE_REPORT    = 3'd6,
        MODE_PING      = 3'd7
    } mode_t;

    // Command broadcast to every door cell when an event is applied.
    typedef struct packed {
        logic               fire;
        mode_t              mode;
        logic               hit;
        logic               sensor;
        logic               pay0;
        logic [LIMIT_W-1:0] limit;
    } door_cmd_t;

    // Status of one door after the event has been applied.
    typedef struct packed {
        logic local_alarm;
        logic central_alarm;
        logic armed;
        logic pending;
    } door_stat_t;

endpackage

>>> sv/mdota_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the alarm block: the event channel and the result channel.
// Depends on mdota_pkg for the field widths.
interface mdota_event_if;
    logic                             valid;
    logic                             ready;
    logic [mdota_pkg::MODE_W-1:0]     mode;
    logic [mdota_pkg::DOOR_W-1:0]     door;
    logic [mdota_pkg::PAYLOAD_W-1:0]  payload;

    modport source (output valid, mode, door, payload, input ready);
    modport sink   (input valid, mode, door, payload, output ready);
endinterface

interface mdota_result_if;
    logic                          valid;
    logic                          ready;
    logic [mdota_pkg::MASK_W-1:0]  local_alarms;
    logic [mdota_pkg::MASK_W-1:0]  central_alarms;
    logic [mdota_pkg::MASK_W-1:0]  disarmed_doors;
    logic [mdota_pkg::MASK_W-1:0]  report_pending;
    logic                          ping_ack;

    modport source (output valid, local_alarms, central_alarms, disarmed_doors,
                    report_pending, ping_ack, input ready);
    modport sink   (input valid, local_alarms, central_alarms, disarmed_doors,
                    report_pending, ping_ack, output ready);
endinterface

>>> sv/mdota_door.sv
`timescale 1ns / 1ps
// State and update logic of one supervised door: flags, tick counter and limits.
// Depends on mdota_pkg for the command and status structs.
module mdota_door (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mdota_pkg::door_cmd_t  cmd,
    output mdota_pkg::door_stat_t stat
);

    logic                              armed_reg, armed_next;
    logic                              open_reg, open_next;
    logic                              local_reg, local_next;
    logic                              central_reg, central_next;
    logic                              reported_reg, reported_next;
    logic [mdota_pkg::ELAPSED_W-1:0]   elapsed_reg, elapsed_next;
    logic [mdota_pkg::LIMIT_W-1:0]     local_lim_reg, local_lim_next;
    logic [mdota_pkg::LIMIT_W-1:0]     cent_lim_reg, cent_lim_next;

    always_comb
    begin
        armed_next     = armed_reg;
        open_next      = open_reg;
        local_next     = local_reg;
        central_next   = central_reg;
        reported_next  = reported_reg;
        elapsed_next   = elapsed_reg;
        local_lim_next = local_lim_reg;
        cent_lim_next  = cent_lim_reg;
        if (cmd.fire)
        begin
            case (cmd.mode)
                mdota_pkg::MODE_TICK:
                begin
                    if (armed_reg && open_reg)
                    begin
                        if (elapsed_reg != mdota_pkg::ELAPSED_MAX)
                        begin
                            elapsed_next = elapsed_reg + 1'b1;
                        end
                        // The local alarm takes precedence; the central one is
                        // only raised on a tick that did not raise the local one.
                        if (elapsed_next >= mdota_pkg::ELAPSED_W'(local_lim_reg) && !local_reg)
                        begin
                            local_next = 1'b1;
                        end
                        else if (elapsed_next >= mdota_pkg::ELAPSED_W'(cent_lim_reg)
                                 && !central_reg)
                        begin
                            central_next = 1'b1;
                        end
                    end
                end
                mdota_pkg::MODE_SENSOR:
                begin
                    if (cmd.sensor && armed_reg)
                    begin
                        open_next = 1'b1;
                    end
                    else
                    begin
                        open_next     = 1'b0;
                        local_next    = 1'b0;
                        central_next  = 1'b0;
                        reported_next = 1'b0;
                        elapsed_next  = '0;
                    end
                end
                mdota_pkg::MODE_CLEAR:
                begin
                    if (cmd.hit)
                    begin
                        local_next    = 1'b0;
                        central_next  = 1'b0;
                        reported_next = 1'b0;
                        elapsed_next  = '0;
                    end
                end
                mdota_pkg::MODE_ARM:
                begin
                    if (cmd.hit)
                    begin
                        armed_next = cmd.pay0;
                    end
                end
                mdota_pkg::MODE_LOCAL_LIM:
                begin
                    if (cmd.hit)
                    begin
                        local_lim_next = cmd.limit;
                    end
                end
                mdota_pkg::MODE_CENT_LIM:
                begin
                    if (cmd.hit)
                    begin
                        cent_lim_next = cmd.limit;
                    end
                end
                mdota_pkg::MODE_REPORT:
                begin
                    // An outcome with no pending report is ignored.
                    if (cmd.hit && central_reg && !reported_reg)
                    begin
                        reported_next = cmd.pay0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg     <= 1'b0;
            open_reg      <= 1'b0;
            local_reg     <= 1'b0;
            central_reg   <= 1'b0;
            reported_reg  <= 1'b0;
            elapsed_reg   <= '0;
            local_lim_reg <= mdota_pkg::LOCAL_RESET;
            cent_lim_reg  <= mdota_pkg::CENTRAL_RESET;
        end
        else
        begin
            armed_reg     <= armed_next;
            open_reg      <= open_next;
            local_reg     <= local_next;
            central_reg   <= central_next;
            reported_reg  <= reported_next;
            elapsed_reg   <= elapsed_next;
            local_lim_reg <= local_lim_next;
            cent_lim_reg  <= cent_lim_next;
        end
    end

    assign stat.local_alarm   = local_next;
    assign stat.central_alarm = central_next;
    assign stat.armed         = armed_next;
    assign stat.pending       = central_next && !reported_next;

endmodule

>>> sv/multi_door_open_timeout_alarm.sv
`timescale 1ns / 1ps
// Top level of the multi-door open-timeout alarm supervisor.
// Depends on mdota_pkg, the channel interfaces in mdota_if and the door cells in mdota_door.
//
//   Channel | Direction | Transaction fields
//   --------+-----------+-----------------------------------------------------------------
//   evt     | in        | mode, door, payload (one event per transaction)
//   res     | out       | local_alarms, central_alarms, disarmed_doors, report_pending,
//           |           | ping_ack (one result per event)
//
// An event is captured in an input register and applied to all door cells in parallel once
// the result register can take it; its result is written to the output register in the
// same cycle as the door cells update, and offered from there. One event per cycle is
// sustained while res does not stall.
// Reset (rst_n, asynchronous) disarms and closes every door, clears alarms, counters and
// report flags, and restores the limits of 300 and 700 ticks.
// A stall on res holds the result register and then the input register; evt.ready drops
// only when both are full.
module multi_door_open_timeout_alarm #(
    parameter int DOOR_COUNT       = mdota_pkg::DOOR_COUNT_DEF,
    parameter int TICKS_PER_SECOND = mdota_pkg::TICKS_PER_SECOND_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    mdota_event_if.sink       evt,
    mdota_result_if.source    res
);

    // Width of the scaled limit product; wide enough to hold the saturation bound as well.
    localparam int PROD_RAW = mdota_pkg::PAYLOAD_W + $clog2(TICKS_PER_SECOND + 1);
    localparam int PROD_W   = (PROD_RAW > mdota_pkg::LIMIT_W) ? PROD_RAW
                                                              : mdota_pkg::LIMIT_W + 1;

    // Input register stage.
    logic                              s1_valid_reg;
    logic [mdota_pkg::MODE_W-1:0]      s1_mode_reg;
    logic [mdota_pkg::DOOR_W-1:0]      s1_door_reg;
    logic [mdota_pkg::PAYLOAD_W-1:0]   s1_payload_reg;

    // Result register stage.
    logic                              out_valid_reg;
    logic [mdota_pkg::MASK_W-1:0]      local_reg, local_next;
    logic [mdota_pkg::MASK_W-1:0]      central_reg, central_next;
    logic [mdota_pkg::MASK_W-1:0]      disarmed_reg, disarmed_next;
    logic [mdota_pkg::MASK_W-1:0]      pending_reg, pending_next;
    logic                              ping_reg;

    logic                              out_free;
    logic                              s1_fire;
    logic                              in_take;
    logic [PROD_W-1:0]                 limit_prod;
    logic [mdota_pkg::LIMIT_W-1:0]     limit_sat;
    logic [DOOR_COUNT-1:0]             sensor_vec;
    mdota_pkg::door_stat_t             stat [DOOR_COUNT];

    // The result register can take a new result when it is empty or being drained.
    assign out_free  = !out_valid_reg || res.ready;
    assign s1_fire   = s1_valid_reg && out_free;
    assign evt.ready = !s1_valid_reg || out_free;
    assign in_take   = evt.valid && evt.ready;

    // Limit in ticks is seconds times the tick rate, saturated to the 15-bit limit range.
    assign limit_prod = PROD_W'(s1_payload_reg) * PROD_W'(TICKS_PER_SECOND);
    assign limit_sat  = (limit_prod > PROD_W'(mdota_pkg::LIMIT_MAX))
                        ? mdota_pkg::LIMIT_MAX
                        : limit_prod[mdota_pkg::LIMIT_W-1:0];

    // Sensor bits beyond the payload width read as zero, so those doors always close.
    assign sensor_vec = DOOR_COUNT'(s1_payload_reg);

    for (genvar k = 0; k < DOOR_COUNT; k++)
    begin : g_door
        mdota_pkg::door_cmd_t cmd;

        assign cmd.fire   = s1_fire;
        assign cmd.mode   = mdota_pkg::mode_t'(s1_mode_reg);
        assign cmd.hit    = ({1'b0, s1_door_reg} == 4'(k));
        assign cmd.sensor = sensor_vec[k];
        assign cmd.pay0   = s1_payload_reg[0];
        assign cmd.limit  = limit_sat;

        mdota_door u_door (
            .clk   (clk),
            .rst_n (rst_n),
            .cmd   (cmd),
            .stat  (stat[k])
        );
    end

    // Mask bits exist only for doors below both the door count and the mask width.
    for (genvar j = 0; j < mdota_pkg::MASK_W; j++)
    begin : g_mask
        if (j < DOOR_COUNT)
        begin : g_live
            assign local_next[j]    = stat[j].local_alarm;
            assign central_next[j]  = stat[j].central_alarm;
            assign disarmed_next[j] = !stat[j].armed;
            assign pending_next[j]  = stat[j].pending;
        end
        else
        begin : g_none
            assign local_next[j]    = 1'b0;
            assign central_next[j]  = 1'b0;
            assign disarmed_next[j] = 1'b0;
            assign pending_next[j]  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_mode_reg    <= evt.mode;
            s1_door_reg    <= evt.door;
            s1_payload_reg <= evt.payload;
        end
        if (s1_fire)
        begin
            local_reg    <= local_next;
            central_reg  <= central_next;
            disarmed_reg <= disarmed_next;
            pending_reg  <= pending_next;
            ping_reg     <= (mdota_pkg::mode_t'(s1_mode_reg) == mdota_pkg::MODE_PING);
        end
    end

    assign res.valid          = out_valid_reg;
    assign res.local_alarms   = local_reg;
    assign res.central_alarms = central_reg;
    assign res.disarmed_doors = disarmed_reg;
    assign res.report_pending = pending_reg;
    assign res.ping_ack       = ping_reg;

endmodule
